[hw/rtl/cube_corner_order_sorter_defines.svh]
// Assertion macros shared by the cube corner order sorter checker.
`ifndef CUBE_CORNER_ORDER_SORTER_DEFINES_SVH
`define CUBE_CORNER_ORDER_SORTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCOS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/ccos_pkg.sv]
// Package with types and constants of the cube corner order sorter.
package ccos_pkg;

    localparam int CORNERS = 8;
    localparam int IDX_BITS = 3;
    localparam int DIR_W = 16;
    localparam int KEY_W = DIR_W + 2;
    localparam int ORDER_W = CORNERS * IDX_BITS;

    typedef logic signed [DIR_W-1:0] t_dir;
    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [IDX_BITS-1:0] t_idx;
    typedef logic [ORDER_W-1:0] t_order;

endpackage

[hw/rtl/ccos_sort.sv]
// Corner key generation and eight-input bitonic sorting network.
module ccos_sort (
    input  ccos_pkg::t_dir   i_dir_x,
    input  ccos_pkg::t_dir   i_dir_y,
    input  ccos_pkg::t_dir   i_dir_z,
    output ccos_pkg::t_order o_corner_order
);

    ccos_pkg::t_key w_x;
    ccos_pkg::t_key w_y;
    ccos_pkg::t_key w_z;

    assign w_x = {{2{i_dir_x[ccos_pkg::DIR_W-1]}}, i_dir_x};
    assign w_y = {{2{i_dir_y[ccos_pkg::DIR_W-1]}}, i_dir_y};
    assign w_z = {{2{i_dir_z[ccos_pkg::DIR_W-1]}}, i_dir_z};

    // Keys and corner indices move together through the compare-exchange stages.
    always_comb begin
        ccos_pkg::t_key   keys [ccos_pkg::CORNERS];
        ccos_pkg::t_idx   idx  [ccos_pkg::CORNERS];
        ccos_pkg::t_key   t_k;
        ccos_pkg::t_idx   t_i;
        logic             swap;
        ccos_pkg::t_order packed_order;
        t_k  = '0;
        t_i  = '0;
        swap = 1'b0;
        for (int c = 0; c < ccos_pkg::CORNERS; c++) begin
            keys[c] = (c[2] ? w_x : '0) + (c[1] ? w_y : '0) + (c[0] ? w_z : '0);
            idx[c]  = ccos_pkg::t_idx'(c);
        end
        for (int k = 2; k <= ccos_pkg::CORNERS; k = k * 2) begin
            for (int j = k / 2; j > 0; j = j / 2) begin
                for (int i = 0; i < ccos_pkg::CORNERS; i++) begin
                    if ((i ^ j) > i) begin
                        if ((i & k) == 0) begin
                            swap = keys[i] > keys[i ^ j];
                        end else begin
                            swap = keys[i] < keys[i ^ j];
                        end
                        if (swap) begin
                            t_k          = keys[i];
                            keys[i]      = keys[i ^ j];
                            keys[i ^ j]  = t_k;
                            t_i          = idx[i];
                            idx[i]       = idx[i ^ j];
                            idx[i ^ j]   = t_i;
                        end
                    end
                end
            end
        end
        packed_order = '0;
        for (int c = 0; c < ccos_pkg::CORNERS; c++) begin
            packed_order[c*ccos_pkg::IDX_BITS +: ccos_pkg::IDX_BITS] = idx[c];
        end
        o_corner_order = packed_order;
    end

endmodule

[hw/rtl/cube_corner_order_sorter.sv]
// Top level of the cube corner order sorter.
// Accepted inputs load the input registers, then the sort result loads the result register.
// Throughput: one transaction per cycle, limited only by output stall.
// The key sums and the six compare-exchange stages sit between the input and result registers.
// Reset is synchronous and active low and clears both valid flags; payload is not reset.
module cube_corner_order_sorter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  ccos_pkg::t_dir          i_dir_x,
    input  ccos_pkg::t_dir          i_dir_y,
    input  ccos_pkg::t_dir          i_dir_z,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output ccos_pkg::t_order        o_corner_order
);

    logic             r_in_valid;
    ccos_pkg::t_dir   r_dir_x;
    ccos_pkg::t_dir   r_dir_y;
    ccos_pkg::t_dir   r_dir_z;
    logic             r_out_valid;
    ccos_pkg::t_order r_order;
    ccos_pkg::t_order n_order;
    logic             w_out_load;
    logic             w_in_load;

    assign w_out_load  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !w_out_load;
    assign w_in_load   = !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_corner_order = r_order;

    ccos_sort u_sort (
        .i_dir_x        (r_dir_x),
        .i_dir_y        (r_dir_y),
        .i_dir_z        (r_dir_z),
        .o_corner_order (n_order)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_in_valid) begin
            r_dir_x <= i_dir_x;
            r_dir_y <= i_dir_y;
            r_dir_z <= i_dir_z;
        end
        if (w_out_load && r_in_valid) begin
            r_order <= n_order;
        end
    end

endmodule

[hw/rtl/ccos_checker.sv]
// Port-level checker for the cube corner order sorter and its bind.
`include "cube_corner_order_sorter_defines.svh"

module ccos_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input ccos_pkg::t_order o_corner_order
);

    logic [ccos_pkg::CORNERS-1:0] w_seen;

    // Every corner must appear exactly once in a result word.
    always_comb begin
        w_seen = '0;
        for (int c = 0; c < ccos_pkg::CORNERS; c++) begin
            w_seen[o_corner_order[c*ccos_pkg::IDX_BITS +: ccos_pkg::IDX_BITS]] = 1'b1;
        end
    end

    `CCOS_ASSERT_IMPLY(a_order_is_permutation, i_clk, i_rst_n, o_out_valid, &w_seen)
    `CCOS_ASSERT_IMPLY(a_no_stall_when_empty, i_clk, i_rst_n, !o_out_valid, !o_in_stall)
    `CCOS_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `CCOS_ASSERT_NEXT(a_order_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_corner_order))

endmodule

bind cube_corner_order_sorter ccos_checker u_ccos_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_corner_order (o_corner_order)
);

[tb/sv/cube_corner_order_sorter_tb.sv]
// Self-checking testbench that ranks cube corners along directed and random directions and checks each order.
module cube_corner_order_sorter_tb;
    import ccos_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int DIRECTED_ITEMS = 21;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT = 400000;

    class corner_order_board;
        t_order pending_orders[$];
        int mismatch_count;
        int checked_count;

        function new();
            mismatch_count = 0;
            checked_count = 0;
        endfunction

        static function t_order rank_corners(t_dir x, t_dir y, t_dir z);
            t_key key [CORNERS];
            t_idx idx [CORNERS];
            t_idx tmp;
            t_key a;
            t_key b;
            t_order order;
            int p;
            bit swap;
            for (int c = 0; c < CORNERS; c++) begin
                key[c] = (((c & 4) != 0) ? t_key'(x) : t_key'(0))
                       + (((c & 2) != 0) ? t_key'(y) : t_key'(0))
                       + (((c & 1) != 0) ? t_key'(z) : t_key'(0));
                idx[c] = t_idx'(c);
            end
            for (int k = 2; k <= CORNERS; k = k << 1) begin
                for (int j = k >> 1; j > 0; j = j >> 1) begin
                    for (int i = 0; i < CORNERS; i++) begin
                        p = i ^ j;
                        if (p > i) begin
                            a = key[idx[i]];
                            b = key[idx[p]];
                            swap = ((i & k) == 0) ? (a > b) : (a < b);
                            if (swap) begin
                                tmp = idx[i];
                                idx[i] = idx[p];
                                idx[p] = tmp;
                            end
                        end
                    end
                end
            end
            order = '0;
            for (int c = 0; c < CORNERS; c++) begin
                order[IDX_BITS*c +: IDX_BITS] = idx[c];
            end
            return order;
        endfunction

        function void note_direction(t_dir x, t_dir y, t_dir z);
            pending_orders.push_back(rank_corners(x, y, z));
        endfunction

        function void check_order(t_order got);
            t_order want;
            if (pending_orders.size() == 0) begin
                $display("%0t: corner order %h arrived with none expected", $time, got);
                mismatch_count++;
                return;
            end
            want = pending_orders.pop_front();
            checked_count++;
            if (got !== want) begin
                $display("%0t: corner order mismatch, expected %h, got %h", $time, want, got);
                mismatch_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_dir i_dir_x;
    t_dir i_dir_y;
    t_dir i_dir_z;
    logic o_out_valid;
    logic i_out_stall;
    t_order o_corner_order;

    corner_order_board board = new();
    int cycle_count = 0;
    int burst_left = 0;

    int directed_vec [DIRECTED_ITEMS][3] = '{
        '{0, 0, 0}, '{16384, 0, 0}, '{0, 16384, 0}, '{0, 0, 16384},
        '{-16384, 0, 0}, '{0, -16384, 0}, '{0, 0, -16384},
        '{16384, 16384, 16384}, '{-16384, -16384, -16384},
        '{32767, -32768, 0}, '{-32768, 32767, -1}, '{16384, -16384, 16384},
        '{1, 1, 1}, '{-1, 2, -1}, '{100, 100, -100}, '{5, -5, 5},
        '{16384, 16384, -16384}, '{8192, -4096, 12288},
        '{-32768, -32768, -32768}, '{32767, 32767, 32767}, '{1, 0, -1}
    };

    cube_corner_order_sorter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_dir_x        (i_dir_x),
        .i_dir_y        (i_dir_y),
        .i_dir_z        (i_dir_z),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_corner_order (o_corner_order)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                board.check_order(o_corner_order);
            end
            if (i_in_valid && !o_in_stall) begin
                board.note_direction(i_dir_x, i_dir_y, i_dir_z);
            end
        end
    end

    initial begin : out_stall_gen
        int pick;
        int len;
        logic stall_on;
        i_out_stall = 1'b0;
        forever begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                stall_on = 1'b0;
                len = $urandom_range(60, 20);
            end else if (pick < 55) begin
                stall_on = 1'b0;
                len = $urandom_range(4, 1);
            end else if (pick < 93) begin
                stall_on = 1'b1;
                len = $urandom_range(3, 1);
            end else begin
                stall_on = 1'b1;
                len = $urandom_range(30, 8);
            end
            repeat (len) begin
                @(negedge i_clk);
                i_out_stall <= stall_on;
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            burst_left = $urandom_range(50, 15);
            return 0;
        end
        if (pick < 55) return 0;
        if (pick < 93) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic t_dir random_component(int mode, int shared);
        int pick;
        pick = $urandom_range(2);
        case (mode)
            0: return t_dir'($urandom_range(32768) - 16384);
            1: return t_dir'($urandom);
            2: return (pick == 0) ? t_dir'(0) : (pick == 1) ? t_dir'(shared) : t_dir'(-shared);
            default: return t_dir'($urandom_range(8) - 4);
        endcase
    endfunction

    task automatic send_direction(input t_dir x, input t_dir y, input t_dir z);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_dir_x <= x;
        i_dir_y <= y;
        i_dir_z <= z;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int pick;
        int mode;
        int shared;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_dir_x = '0;
        i_dir_y = '0;
        i_dir_z = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_ITEMS; n++) begin
            send_direction(t_dir'(directed_vec[n][0]), t_dir'(directed_vec[n][1]),
                           t_dir'(directed_vec[n][2]));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(99);
            mode = (pick < 65) ? 0 : (pick < 80) ? 1 : (pick < 95) ? 2 : 3;
            shared = $urandom_range(16384, 1);
            send_direction(random_component(mode, shared), random_component(mode, shared),
                           random_component(mode, shared));
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending_orders.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d corner orders from %0d directed and %0d random directions.",
                 board.checked_count, DIRECTED_ITEMS, RANDOM_ITEMS);
        $display("Directions mixed zero, axis, tied and out-of-range components under stalls.");
        if (board.mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

[cube_corner_order_sorter.f]
+incdir+hw/rtl
hw/rtl/ccos_pkg.sv
hw/rtl/ccos_sort.sv
hw/rtl/cube_corner_order_sorter.sv
hw/rtl/ccos_checker.sv
tb/sv/cube_corner_order_sorter_tb.sv
